/* rtl/tlg_pkg.sv */
package tlg_pkg;

    localparam int GAIN_W   = 24;
    localparam int COUNT_W  = 17;
    localparam int DEPTH_W  = 23;
    localparam int PERIOD_W = 16;
    localparam int PHASE_W  = 32;
    localparam int ROM_W    = 31;
    localparam int ACC_W    = 31;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [GAIN_W-1:0] GAIN_HALF = 24'h800000;

    // floor(x / 100) as (x * DIV100_MUL) >> DIV100_SHIFT, exact for x < 2^32
    localparam logic [31:0] DIV100_MUL   = 32'd2748779070;
    localparam int          DIV100_SHIFT = 38;
    localparam logic [6:0]  SMOOTH_KEEP  = 7'd99;

    localparam longint unsigned Q30_ONE     = 64'h40000000;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        MODE_SINE     = 2'd0,
        MODE_SQUARE   = 2'd1,
        MODE_TRIANGLE = 2'd2,
        MODE_RAMP     = 2'd3
    } t_lfo_mode;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_DEPTH  = 3'd1,
        REG_PERIOD = 3'd2,
        REG_RAMP   = 3'd3,
        REG_PHASE  = 3'd4
    } t_reg_idx;

    localparam t_lfo_mode            RST_MODE   = MODE_SINE;
    localparam logic [DEPTH_W-1:0]   RST_DEPTH  = 23'd5033165;
    localparam logic [PERIOD_W-1:0]  RST_PERIOD = 16'd24000;
    localparam logic [DEPTH_W-1:0]   RST_RAMP   = 23'd419;
    localparam logic [PHASE_W-1:0]   RST_PHASE  = 32'd178957;

    typedef struct packed {
        t_lfo_mode             mode;
        logic [DEPTH_W-1:0]    depth;
        logic [PERIOD_W-1:0]   period;
        logic [DEPTH_W-1:0]    ramp_step;
        logic [PHASE_W-1:0]    phase_step;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic lfo_step;
        logic div_step;
        logic gain_step;
        logic mult_step;
        logic out_load;
    } t_dp_cmd;

    // quarter-wave sine in q30 for rom entry j, odd taylor series to x^11
    function automatic logic [ROM_W-1:0] sine_q30(input int j, input int shift);
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        r  = longint'(j) << shift;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        return ROM_W'(s);
    endfunction

endpackage

/* rtl/tlg_cfg_regs.sv */
module tlg_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [tlg_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [tlg_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [tlg_pkg::PDATA_W-1:0]   o_prdata,
    output logic                          o_pready,
    output tlg_pkg::t_cfg                 o_cfg,
    output logic                          o_cfg_wr
);

    tlg_pkg::t_cfg    r_cfg;
    tlg_pkg::t_cfg    n_cfg;
    tlg_pkg::t_reg_idx w_idx;
    logic             w_wr;
    logic             w_known;

    assign o_pready = 1'b1;
    assign w_idx    = tlg_pkg::t_reg_idx'(i_paddr[tlg_pkg::PADDR_W-1:2]);
    assign w_wr     = i_psel & i_penable & i_pwrite;

    always_comb begin
        n_cfg   = r_cfg;
        w_known = 1'b1;
        unique case (w_idx)
            tlg_pkg::REG_MODE:   n_cfg.mode       = tlg_pkg::t_lfo_mode'(i_pwdata[1:0]);
            tlg_pkg::REG_DEPTH:  n_cfg.depth      = i_pwdata[tlg_pkg::DEPTH_W-1:0];
            tlg_pkg::REG_PERIOD: n_cfg.period     = i_pwdata[tlg_pkg::PERIOD_W-1:0];
            tlg_pkg::REG_RAMP:   n_cfg.ramp_step  = i_pwdata[tlg_pkg::DEPTH_W-1:0];
            tlg_pkg::REG_PHASE:  n_cfg.phase_step = i_pwdata[tlg_pkg::PHASE_W-1:0];
            default:             w_known          = 1'b0;
        endcase
    end

    // writes to unused addresses leave everything alone, gain included
    assign o_cfg_wr = w_wr & w_known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= tlg_pkg::RST_MODE;
            r_cfg.depth      <= tlg_pkg::RST_DEPTH;
            r_cfg.period     <= tlg_pkg::RST_PERIOD;
            r_cfg.ramp_step  <= tlg_pkg::RST_RAMP;
            r_cfg.phase_step <= tlg_pkg::RST_PHASE;
        end else if (o_cfg_wr) begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            tlg_pkg::REG_MODE:   o_prdata = tlg_pkg::PDATA_W'(r_cfg.mode);
            tlg_pkg::REG_DEPTH:  o_prdata = tlg_pkg::PDATA_W'(r_cfg.depth);
            tlg_pkg::REG_PERIOD: o_prdata = tlg_pkg::PDATA_W'(r_cfg.period);
            tlg_pkg::REG_RAMP:   o_prdata = tlg_pkg::PDATA_W'(r_cfg.ramp_step);
            tlg_pkg::REG_PHASE:  o_prdata = r_cfg.phase_step;
            default:             o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/tlg_ctrl.sv */
module tlg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output tlg_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LFO  = 6'b000010,
        S_DIV  = 6'b000100,
        S_GAIN = 6'b001000,
        S_MULT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid & ~i_m_tready;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LFO;
                end
            end
            S_LFO: begin
                o_cmd.lfo_step = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain_step = 1'b1;
                n_state         = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult_step = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                // wait here only while the previous result is still unclaimed
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("result register loaded over an untaken result");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> ##4 o_cmd.mult_step)
        else $error("sample did not reach the multiply step on time");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(o_cmd.out_load))
        else $error("output valid raised without a result load");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.lfo_step || o_cmd.div_step || o_cmd.gain_step || o_cmd.mult_step)
            |-> !o_s_tready)
        else $error("input ready while a sample is in work");

endmodule

/* rtl/tlg_datapath.sv */
module tlg_datapath #(
    parameter int SAMPLE_BITS  = 24,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tlg_pkg::t_cfg                     i_cfg,
    input  logic                              i_cfg_wr,
    input  tlg_pkg::t_dp_cmd                  i_cmd,
    input  logic [SAMPLE_BITS-1:0]            i_audio,
    output logic [SAMPLE_BITS-1:0]            o_audio,
    output logic [tlg_pkg::GAIN_W-1:0]        o_gain
);

    localparam int IDX_BITS  = $clog2(SINE_ENTRIES);
    localparam int QBITS     = IDX_BITS - 2;
    localparam int QTR       = SINE_ENTRIES / 4;
    localparam int ROM_AW    = QBITS + 1;
    localparam int ROM_SHIFT = 32 - IDX_BITS;
    localparam int GW        = tlg_pkg::GAIN_W;
    localparam int CW        = tlg_pkg::COUNT_W;

    // lfo state
    logic [CW-1:0]          r_count;
    logic [GW-1:0]          r_gain;
    logic [GW-1:0]          r_target;
    logic                   r_falling;
    logic [CW-1:0]          n_count;
    logic [GW-1:0]          n_gain;
    logic [GW-1:0]          n_target;
    logic                   n_falling;

    // per-sample working registers
    logic [SAMPLE_BITS-1:0] r_mag;
    logic                   r_neg;
    logic [IDX_BITS-1:0]    r_phase_idx;
    logic [tlg_pkg::ACC_W-1:0] r_acc;
    logic [tlg_pkg::ROM_W-1:0] r_sine;
    logic                   r_sine_neg;
    logic [GW-1:0]          r_quot;
    logic [SAMPLE_BITS-1:0] r_pm;
    logic [SAMPLE_BITS-1:0] r_out_audio;
    logic [GW-1:0]          r_out_gain;

    logic [tlg_pkg::ROM_W-1:0] w_sine_rom [QTR+1];

    logic [GW-1:0]          w_lo;
    logic [GW-1:0]          w_hi;
    logic                   w_restart;
    logic [GW-1:0]          w_new_target;
    logic [GW+1:0]          w_tri_sum;
    logic [GW-1:0]          w_tri_gain;
    logic                   w_tri_rev;
    logic [GW:0]            w_ramp_sum;
    logic                   w_ramp_wrap;
    logic                   w_sq_toggle;
    logic [CW+tlg_pkg::PHASE_W-1:0] w_phase_prod;
    logic [tlg_pkg::ACC_W-1:0] w_acc;
    logic [62:0]            w_div_prod;
    logic [1:0]             w_quad;
    logic [QBITS-1:0]       w_qidx;
    logic [ROM_AW-1:0]      w_rom_addr;
    logic [tlg_pkg::DEPTH_W+tlg_pkg::ROM_W-1:0] w_swing_prod;
    logic [GW-1:0]          w_swing;
    logic [GW-1:0]          w_sine_gain;
    logic [SAMPLE_BITS+GW-1:0] w_prod;

    genvar gi;
    for (gi = 0; gi <= QTR; gi++) begin : g_rom
        assign w_sine_rom[gi] = tlg_pkg::sine_q30(gi, ROM_SHIFT);
    end

    assign w_lo = tlg_pkg::GAIN_HALF - {1'b0, i_cfg.depth};
    assign w_hi = tlg_pkg::GAIN_HALF + {1'b0, i_cfg.depth};

    // square
    assign w_sq_toggle = {r_count, 1'b0} >= (CW+1)'(i_cfg.period);

    // triangle, saturated to the gain range
    always_comb begin
        if (r_falling) begin
            w_tri_sum = {2'b00, r_gain} - {2'b00, i_cfg.ramp_step, 1'b0};
        end else begin
            w_tri_sum = {2'b00, r_gain} + {2'b00, i_cfg.ramp_step, 1'b0};
        end
        priority if (w_tri_sum[GW+1]) begin
            w_tri_gain = '0;
        end else if (w_tri_sum[GW]) begin
            w_tri_gain = '1;
        end else begin
            w_tri_gain = w_tri_sum[GW-1:0];
        end
    end
    assign w_tri_rev = (w_tri_gain >= w_hi) || (w_tri_gain <= w_lo);

    // ramp
    assign w_ramp_sum  = {1'b0, r_target} + (GW+1)'(i_cfg.ramp_step);
    assign w_ramp_wrap = w_ramp_sum >= {1'b0, w_hi};

    always_comb begin
        w_new_target = r_target;
        w_restart    = 1'b0;
        n_falling    = r_falling;
        unique case (i_cfg.mode)
            tlg_pkg::MODE_SINE: begin
                w_restart = (r_count == CW'(i_cfg.period));
            end
            tlg_pkg::MODE_SQUARE: begin
                w_restart = w_sq_toggle;
                if (w_sq_toggle) begin
                    w_new_target = (r_target == w_lo) ? w_hi : w_lo;
                end
            end
            tlg_pkg::MODE_TRIANGLE: begin
                w_restart = w_tri_rev;
                n_falling = r_falling ^ w_tri_rev;
            end
            tlg_pkg::MODE_RAMP: begin
                w_restart    = w_ramp_wrap;
                w_new_target = w_ramp_wrap ? w_lo : w_ramp_sum[GW-1:0];
            end
            default: w_restart = 1'b0;
        endcase
        n_count  = (w_restart ? '0 : r_count) + CW'(1);
        n_target = w_new_target;
    end

    assign w_phase_prod = r_count * i_cfg.phase_step;
    assign w_acc = tlg_pkg::ACC_W'(r_gain) * tlg_pkg::ACC_W'(tlg_pkg::SMOOTH_KEEP)
                 + tlg_pkg::ACC_W'(w_new_target);
    assign w_div_prod = r_acc * tlg_pkg::DIV100_MUL;

    // quadrant folding onto the quarter-wave rom
    assign w_quad = r_phase_idx[IDX_BITS-1 -: 2];
    assign w_qidx = r_phase_idx[QBITS-1:0];
    assign w_rom_addr = w_quad[0] ? (ROM_AW'(QTR) - {1'b0, w_qidx}) : {1'b0, w_qidx};

    assign w_swing_prod = i_cfg.depth * r_sine;
    assign w_swing      = w_swing_prod[30 +: GW];
    assign w_sine_gain  = r_sine_neg ? (tlg_pkg::GAIN_HALF - w_swing)
                                     : (tlg_pkg::GAIN_HALF + w_swing);

    assign w_prod = r_mag * r_gain;

    always_comb begin
        n_gain = r_gain;
        priority if (i_cfg_wr) begin
            n_gain = tlg_pkg::GAIN_HALF;
        end else if (i_cmd.lfo_step && i_cfg.mode == tlg_pkg::MODE_TRIANGLE) begin
            n_gain = w_tri_gain;
        end else if (i_cmd.gain_step && i_cfg.mode == tlg_pkg::MODE_SINE) begin
            n_gain = w_sine_gain;
        end else if (i_cmd.gain_step && i_cfg.mode != tlg_pkg::MODE_TRIANGLE) begin
            n_gain = r_quot;
        end else begin
            n_gain = r_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_gain    <= tlg_pkg::GAIN_HALF;
            r_target  <= '0;
            r_falling <= 1'b0;
        end else begin
            r_gain <= n_gain;
            if (i_cmd.lfo_step) begin
                r_count   <= n_count;
                r_target  <= n_target;
                r_falling <= n_falling;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_neg <= i_audio[SAMPLE_BITS-1];
            r_mag <= i_audio[SAMPLE_BITS-1] ? (~i_audio + SAMPLE_BITS'(1)) : i_audio;
        end
        if (i_cmd.lfo_step) begin
            r_phase_idx <= w_phase_prod[tlg_pkg::PHASE_W-1 -: IDX_BITS];
            r_acc       <= w_acc;
        end
        if (i_cmd.div_step) begin
            r_sine     <= w_sine_rom[w_rom_addr];
            r_sine_neg <= w_quad[1];
            r_quot     <= w_div_prod[tlg_pkg::DIV100_SHIFT +: GW];
        end
        if (i_cmd.mult_step) begin
            r_pm <= w_prod[GW +: SAMPLE_BITS];
        end
        if (i_cmd.out_load) begin
            r_out_audio <= r_neg ? (~r_pm + SAMPLE_BITS'(1)) : r_pm;
            r_out_gain  <= r_gain;
        end
    end

    assign o_audio = r_out_audio;
    assign o_gain  = r_out_gain;

endmodule

/* rtl/tremolo_lfo_gain.sv */
// channel   dir  handshake             payload
// s stream  in   i_s_tvalid/o_s_tready i_s_tdata: audio_in
// m stream  out  o_m_tvalid/i_m_tready o_m_tdata: audio_out, gain_now
// apb cfg   in   psel/penable/pready   lfo_mode, swing_depth, period_samples,
//                                      ramp_step, phase_step at 0x0..0x10
//
// a sample passes these steps from acceptance to the next acceptance: lfo update,
// smoothing divide and sine rom read, gain, multiply, result load
// synchronous active-low reset clears control and lfo state, gain to one half
// a stalled output holds its result; the next sample is taken meanwhile and
// waits at the result load step until the output is free
module tremolo_lfo_gain #(
    parameter int SAMPLE_BITS  = 24,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // [SAMPLE_BITS-1:0] audio_in, zero filled to bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       i_s_tdata,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // [SAMPLE_BITS-1:0] audio_out, [SAMPLE_BITS+23:SAMPLE_BITS] gain_now
    output logic [((SAMPLE_BITS+24+7)/8)*8-1:0]    o_m_tdata,
    input  logic                                   i_psel,
    input  logic                                   i_penable,
    input  logic                                   i_pwrite,
    input  logic [tlg_pkg::PADDR_W-1:0]            i_paddr,
    input  logic [tlg_pkg::PDATA_W-1:0]            i_pwdata,
    output logic [tlg_pkg::PDATA_W-1:0]            o_prdata,
    output logic                                   o_pready
);

    localparam int OUT_W = ((SAMPLE_BITS + 24 + 7) / 8) * 8;

    tlg_pkg::t_cfg                w_cfg;
    logic                         w_cfg_wr;
    tlg_pkg::t_dp_cmd             w_cmd;
    logic [SAMPLE_BITS-1:0]       w_audio_out;
    logic [tlg_pkg::GAIN_W-1:0]   w_gain_out;

    tlg_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg),
        .o_cfg_wr  (w_cfg_wr)
    );

    tlg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    tlg_datapath #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_cfg_wr (w_cfg_wr),
        .i_cmd    (w_cmd),
        .i_audio  (i_s_tdata[SAMPLE_BITS-1:0]),
        .o_audio  (w_audio_out),
        .o_gain   (w_gain_out)
    );

    assign o_m_tdata = OUT_W'({w_gain_out, w_audio_out});

endmodule

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF      = 5;
    localparam int          RST_CYCLES    = 5;
    localparam int          MAX_GAP       = 17;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 20;
    localparam int unsigned LIMIT         = 3_000_000;
    localparam int          RANDOM_ITEMS  = 1400;
    localparam int unsigned SWING_MAX     = 7549747;
    localparam longint unsigned LUT_SIZE  = 1024;

    typedef struct packed {
        logic [23:0] audio_out;
        logic [23:0] gain_now;
    } t_mod_result;

    class gain_scoreboard;
        tlg_pkg::t_lfo_mode                mode;
        logic [tlg_pkg::DEPTH_W-1:0]       depth;
        logic [tlg_pkg::PERIOD_W-1:0]      period;
        logic [tlg_pkg::DEPTH_W-1:0]       ramp;
        logic [tlg_pkg::PHASE_W-1:0]       phase_inc;
        logic [tlg_pkg::COUNT_W-1:0]       count;
        logic [tlg_pkg::GAIN_W-1:0]        gain;
        logic [tlg_pkg::GAIN_W-1:0]        target;
        logic                              falling;
        t_mod_result                       modulated_q[$];
        int                                errors;

        function new();
            mode      = tlg_pkg::RST_MODE;
            depth     = tlg_pkg::RST_DEPTH;
            period    = tlg_pkg::RST_PERIOD;
            ramp      = tlg_pkg::RST_RAMP;
            phase_inc = tlg_pkg::RST_PHASE;
            count     = '0;
            gain      = tlg_pkg::GAIN_HALF;
            target    = '0;
            falling   = 1'b0;
            errors    = 0;
        endfunction

        function int pending();
            return modulated_q.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                tlg_pkg::REG_MODE:   mode = tlg_pkg::t_lfo_mode'(val[1:0]);
                tlg_pkg::REG_DEPTH:  depth = val[tlg_pkg::DEPTH_W-1:0];
                tlg_pkg::REG_PERIOD: period = val[tlg_pkg::PERIOD_W-1:0];
                tlg_pkg::REG_RAMP:   ramp = val[tlg_pkg::DEPTH_W-1:0];
                tlg_pkg::REG_PHASE:  phase_inc = val;
                default:             return;
            endcase
            gain = tlg_pkg::GAIN_HALF;
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                tlg_pkg::REG_MODE:   return {30'd0, mode};
                tlg_pkg::REG_DEPTH:  return {9'd0, depth};
                tlg_pkg::REG_PERIOD: return {16'd0, period};
                tlg_pkg::REG_RAMP:   return {9'd0, ramp};
                tlg_pkg::REG_PHASE:  return phase_inc;
                default:             return '0;
            endcase
        endfunction

        // one-pole smoother, coefficient 0.99
        function logic [23:0] one_pole(logic [23:0] g, logic [23:0] t);
            longint unsigned acc;
            acc = longint'(g) * 99 + longint'(t);
            return 24'(acc / 100);
        endfunction

        function void note_sample(logic [23:0] smp);
            logic [23:0]      lo;
            logic [23:0]      hi;
            longint           g;
            longint           d;
            longint unsigned  t;
            logic [31:0]      ph;
            longint unsigned  k;
            longint unsigned  p;
            logic [1:0]       quad;
            longint unsigned  r;
            longint unsigned  x;
            longint unsigned  x2;
            longint unsigned  s;
            longint unsigned  swing;
            int               n;
            logic             neg;
            logic [23:0]      mag;
            logic [47:0]      prod;
            logic [23:0]      pm;
            t_mod_result      e;

            lo = tlg_pkg::GAIN_HALF - {1'b0, depth};
            hi = tlg_pkg::GAIN_HALF + {1'b0, depth};
            case (mode)
                tlg_pkg::MODE_SQUARE: begin
                    if (2 * int'(count) >= int'(period)) begin
                        target = (target == lo) ? hi : lo;
                        count  = '0;
                    end
                    gain = one_pole(gain, target);
                end
                tlg_pkg::MODE_TRIANGLE: begin
                    g = longint'(gain);
                    d = 2 * longint'(ramp);
                    g = falling ? g - d : g + d;
                    if (g < 0) g = 0;
                    if (g > 64'hFFFFFF) g = 64'hFFFFFF;
                    gain = g[23:0];
                    if (gain >= hi || gain <= lo) begin
                        falling = !falling;
                        count   = '0;
                    end
                end
                tlg_pkg::MODE_RAMP: begin
                    t = longint'(target) + longint'(ramp);
                    if (t >= longint'(hi)) begin
                        t     = longint'(lo);
                        count = '0;
                    end
                    target = t[23:0];
                    gain   = one_pole(gain, target);
                end
                default: begin
                    ph   = 32'(longint'(count) * longint'(phase_inc));
                    k    = (longint'(ph) * LUT_SIZE) >> 32;
                    p    = (k << 32) / LUT_SIZE;
                    quad = p[31:30];
                    r    = p & (tlg_pkg::Q30_ONE - 1);
                    if (quad[0]) r = tlg_pkg::Q30_ONE - r;
                    x    = (r * tlg_pkg::HALF_PI_Q30) >> 30;
                    x2   = (x * x) >> 30;
                    // nested horner form, divisors (2n)(2n+1) from the x^11 term down
                    t    = tlg_pkg::Q30_ONE;
                    for (n = 5; n >= 1; n--) begin
                        t = tlg_pkg::Q30_ONE
                          - ((x2 * t) >> 30) / longint'((2 * n) * (2 * n + 1));
                    end
                    s = (x * t) >> 30;
                    if (s > tlg_pkg::Q30_ONE) s = tlg_pkg::Q30_ONE;
                    swing = (longint'(depth) * s) >> 30;
                    gain  = quad[1] ? 24'(longint'(tlg_pkg::GAIN_HALF) - swing)
                                    : 24'(longint'(tlg_pkg::GAIN_HALF) + swing);
                    if (count == {1'b0, period}) count = '0;
                end
            endcase
            count = count + 1'b1;

            neg  = smp[23];
            mag  = neg ? (~smp + 24'd1) : smp;
            prod = mag * gain;
            pm   = prod[47:24];
            e.audio_out = neg ? (~pm + 24'd1) : pm;
            e.gain_now  = gain;
            modulated_q.push_back(e);
        endfunction

        function void check_result(logic [47:0] beat);
            t_mod_result e;
            if (modulated_q.size() == 0) begin
                $display("%0t unexpected result: expected none, got %h", $time, beat);
                errors++;
                return;
            end
            e = modulated_q.pop_front();
            if (beat[23:0] !== e.audio_out) begin
                $display("%0t audio_out mismatch: expected %h, got %h",
                         $time, e.audio_out, beat[23:0]);
                errors++;
            end
            if (beat[47:24] !== e.gain_now) begin
                $display("%0t gain_now mismatch: expected %h, got %h",
                         $time, e.gain_now, beat[47:24]);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [23:0]                    i_s_tdata;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [47:0]                    o_m_tdata;
    logic                           i_psel;
    logic                           i_penable;
    logic                           i_pwrite;
    logic [tlg_pkg::PADDR_W-1:0]    i_paddr;
    logic [tlg_pkg::PDATA_W-1:0]    i_pwdata;
    logic [tlg_pkg::PDATA_W-1:0]    o_prdata;
    logic                           o_pready;

    gain_scoreboard sb;
    bit             idle_on;
    bit             hold_pending;
    int unsigned    rx_left;
    int unsigned    cycles;

    tremolo_lfo_gain u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.note_sample(i_s_tdata);
        end
    end

    // output side: per-transfer stall, plus a long hold on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
            rx_left = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
        end
        if (hold_pending) begin
            hold_pending = 1'b0;
            rx_left      = HOLD_CYCLES;
        end
        if (rx_left != 0) begin
            rx_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic apb_xfer(input logic wr, input logic [tlg_pkg::PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= wr;
        i_paddr   <= addr;
        i_pwdata  <= wdata;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        rdata = o_prdata;
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        apb_xfer(1'b1, {idx, 2'b00}, val, rd);
        sb.write_reg(idx, val);
        if (idx <= tlg_pkg::REG_PHASE) begin
            apb_xfer(1'b0, {idx, 2'b00}, '0, rd);
            if (rd !== sb.reg_value(idx)) begin
                $display("%0t register %0d readback: expected %h, got %h",
                         $time, idx, sb.reg_value(idx), rd);
                sb.errors++;
            end
        end
    endtask

    task automatic send_sample(input logic [23:0] smp);
        int unsigned gap;
        gap = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= smp;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic quiesce();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(7, 0))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_value(logic [31:0] lo, logic [31:0] hi,
                                               logic [31:0] top, logic [31:0] small_max);
        case ($urandom_range(6, 0))
            0:       return lo;
            1:       return hi;
            2:       return top;
            3, 4:    return $urandom_range(small_max, lo);
            5:       return $urandom & top;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    initial begin
        int unsigned total;
        int unsigned n;
        int          phase_no;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_m_tready <= 1'b0;
        i_psel     <= 1'b0;
        i_penable  <= 1'b0;
        i_pwrite   <= 1'b0;
        i_paddr    <= '0;
        i_pwdata   <= '0;
        sb           = new();
        idle_on      = 1'b1;
        hold_pending = 1'b0;
        rx_left      = 0;
        cycles       = 0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sine at reset settings, sample extremes
        send_sample(24'h000000);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'hFFFFFF);
        send_sample(24'h000001);

        // short sine period restarts the counter, half-turn phase step
        quiesce();
        cfg_write(tlg_pkg::REG_DEPTH, SWING_MAX);
        cfg_write(tlg_pkg::REG_PERIOD, 32'd3);
        cfg_write(tlg_pkg::REG_PHASE, 32'h80000000);
        repeat (5) send_sample(rand_sample());

        // square: target starts off lo, then toggles every sample with period 0 and 1
        quiesce();
        cfg_write(tlg_pkg::REG_MODE, tlg_pkg::MODE_SQUARE);
        cfg_write(tlg_pkg::REG_PERIOD, 32'd0);
        repeat (3) send_sample(rand_sample());
        quiesce();
        cfg_write(tlg_pkg::REG_PERIOD, 32'd1);
        repeat (2) send_sample(rand_sample());

        // triangle with a huge step overshoots and saturates both ways
        quiesce();
        cfg_write(tlg_pkg::REG_MODE, tlg_pkg::MODE_TRIANGLE);
        cfg_write(tlg_pkg::REG_RAMP, SWING_MAX);
        repeat (3) send_sample(rand_sample());
        // write to an unmapped register leaves the gain alone
        quiesce();
        cfg_write(3'(tlg_pkg::REG_PHASE) + 3'd1, $urandom);
        repeat (2) send_sample(rand_sample());

        // ramp: target left at the old lo now sits below the new lo
        quiesce();
        cfg_write(tlg_pkg::REG_MODE, tlg_pkg::MODE_RAMP);
        cfg_write(tlg_pkg::REG_DEPTH, 32'd0);
        cfg_write(tlg_pkg::REG_RAMP, 32'd1000);
        repeat (4) send_sample(rand_sample());

        total = 0;
        for (phase_no = 0; total < RANDOM_ITEMS; phase_no++) begin
            quiesce();
            if ($urandom_range(3, 0) != 0)
                cfg_write(tlg_pkg::REG_MODE, $urandom_range(3, 0));
            if ($urandom_range(1, 0) != 0)
                cfg_write(tlg_pkg::REG_DEPTH, pick_value(0, SWING_MAX, 32'h7FFFFF, 2000));
            if ($urandom_range(1, 0) != 0)
                cfg_write(tlg_pkg::REG_PERIOD, pick_value(0, 65535, 32'hFFFF, 64));
            if ($urandom_range(1, 0) != 0)
                cfg_write(tlg_pkg::REG_RAMP,
                          pick_value(0, SWING_MAX, 32'h7FFFFF, 32'h40000));
            if ($urandom_range(1, 0) != 0)
                cfg_write(tlg_pkg::REG_PHASE,
                          pick_value(0, 32'h80000000, 32'hFFFFFFFF, 32'h1000000));
            if ($urandom_range(7, 0) == 0)
                cfg_write(3'($urandom_range(7, int'(tlg_pkg::REG_PHASE) + 1)), $urandom);
            n       = $urandom_range(80, 10);
            idle_on = ($urandom_range(3, 0) != 0);
            // output held off while samples keep coming, so the input backs up
            if (phase_no == 2 || $urandom_range(19, 0) == 0) begin
                idle_on      = 1'b0;
                hold_pending = 1'b1;
            end
            repeat (n) send_sample(rand_sample());
            total += n;
        end

        quiesce();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
